### rtl/core/lcfs_pkg.sv
// Shared types, widths and codes for the linear color fade stepper.
// No dependencies; used by every module under rtl/core.
package lcfs_pkg;

    localparam int CH_NUM     = 3;     // color channels per track
    localparam int CH_W       = 2;     // channel index width
    localparam int BYTE_W     = 8;
    localparam int OPCODE_W   = 2;
    localparam int TRACK_W    = 4;     // width of the track field
    localparam int TRACK_SPAN = 16;    // tracks the track field can address
    localparam int STEPS_W    = 16;
    localparam int INC_W      = 16;
    localparam int ACC_W      = 32;
    localparam int FRAC_BITS  = 5;     // accumulator holds 1/32 step units
    localparam int Q_W        = ACC_W - FRAC_BITS;  // whole-step count q
    localparam int DIFF_W     = BYTE_W + 1;         // end - start
    localparam int SN_W       = BYTE_W + STEPS_W;   // start * N
    localparam int NUM_W      = 36;    // signed blend numerator
    localparam int MAG_W      = NUM_W - 1;          // its magnitude
    localparam int REM_W      = STEPS_W;            // divider remainder
    localparam int DIV_STEPS  = MAG_W;              // one quotient bit per cycle
    localparam int CNT_W      = 6;

    localparam int NUM_TRACKS_DEF = 16;

    localparam logic [ACC_W-1:0] ACC_START = ACC_W'(32'h20);
    localparam logic [INC_W-1:0] INC_RESET = INC_W'(1);

    // opcodes; the unused code behaves as a read
    localparam logic [OPCODE_W-1:0] OP_START = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_STEP  = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_READ  = 2'd2;

    typedef logic [CH_NUM-1:0][BYTE_W-1:0] bytes_t;

    typedef struct packed {
        logic [ACC_W-1:0]   acc;
        logic [STEPS_W-1:0] steps;
        bytes_t             start_b;
        bytes_t             end_b;
        bytes_t             blend;
    } track_rec_t;

endpackage

### rtl/core/lcfs_track_store.sv
// Track table: one record per fade track, held in flops and cleared at reset.
// Depends on lcfs_pkg.
module lcfs_track_store #(
    parameter int DEPTH = lcfs_pkg::TRACK_SPAN
) (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_idx,
    output lcfs_pkg::track_rec_t                       rd_rec,
    input  logic                                       wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_idx,
    input  lcfs_pkg::track_rec_t                       wr_rec
);

    lcfs_pkg::track_rec_t rec_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DEPTH; i++) begin
                rec_reg[i] <= '0;
            end
        end else if (wr_en) begin
            rec_reg[wr_idx] <= wr_rec;
        end
    end

    assign rd_rec = rec_reg[rd_idx];

endmodule

### rtl/core/lcfs_divider.sv
// Three-lane restoring divider: signed numerators over one unsigned divisor,
// one quotient bit per cycle, truncation toward zero, low byte of each quotient.
// Depends on lcfs_pkg.
module lcfs_divider (
    input  logic                                                  aclk,
    input  logic                                                  aresetn,
    input  logic                                                  start,
    input  logic [lcfs_pkg::CH_NUM-1:0][lcfs_pkg::NUM_W-1:0]      dividend,
    input  logic [lcfs_pkg::STEPS_W-1:0]                          divisor,
    output logic                                                  done,
    output lcfs_pkg::bytes_t                                      quo_lo
);

    logic [lcfs_pkg::CNT_W-1:0]                          cnt_reg, cnt_next;
    logic                                                busy_reg, busy_next;
    logic                                                done_reg, done_next;
    logic [lcfs_pkg::CH_NUM-1:0]                         neg_reg, neg_next;
    logic [lcfs_pkg::CH_NUM-1:0][lcfs_pkg::MAG_W-1:0]    sh_reg, sh_next;
    logic [lcfs_pkg::CH_NUM-1:0][lcfs_pkg::REM_W-1:0]    rem_reg, rem_next;
    logic [lcfs_pkg::REM_W-1:0]                          dvs_reg, dvs_next;

    logic [lcfs_pkg::CH_NUM-1:0][lcfs_pkg::NUM_W-1:0]    mag;
    logic [lcfs_pkg::CH_NUM-1:0][lcfs_pkg::REM_W:0]      trial;
    logic [lcfs_pkg::CH_NUM-1:0][lcfs_pkg::REM_W:0]      trial_sub;
    logic [lcfs_pkg::CH_NUM-1:0]                         fits;

    always_comb begin
        for (int i = 0; i < lcfs_pkg::CH_NUM; i++) begin
            mag[i]       = dividend[i][lcfs_pkg::NUM_W-1] ? ('0 - dividend[i]) : dividend[i];
            trial[i]     = {rem_reg[i], sh_reg[i][lcfs_pkg::MAG_W-1]};
            trial_sub[i] = trial[i] - {1'b0, dvs_reg};
            fits[i]      = (trial[i] >= {1'b0, dvs_reg});
        end
    end

    always_comb begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        neg_next  = neg_reg;
        sh_next   = sh_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = lcfs_pkg::CNT_W'(lcfs_pkg::DIV_STEPS - 1);
            dvs_next  = divisor;
            for (int i = 0; i < lcfs_pkg::CH_NUM; i++) begin
                neg_next[i] = dividend[i][lcfs_pkg::NUM_W-1];
                sh_next[i]  = mag[i][lcfs_pkg::MAG_W-1:0];
                rem_next[i] = '0;
            end
        end else if (busy_reg) begin
            for (int i = 0; i < lcfs_pkg::CH_NUM; i++) begin
                rem_next[i] = fits[i] ? trial_sub[i][lcfs_pkg::REM_W-1:0]
                                      : trial[i][lcfs_pkg::REM_W-1:0];
                sh_next[i]  = {sh_reg[i][lcfs_pkg::MAG_W-2:0], fits[i]};
            end
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        neg_reg <= neg_next;
        sh_reg  <= sh_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done = done_reg;

    // restore the sign on the kept byte
    always_comb begin
        for (int i = 0; i < lcfs_pkg::CH_NUM; i++) begin
            quo_lo[i] = neg_reg[i] ? (lcfs_pkg::BYTE_W'(0) - sh_reg[i][lcfs_pkg::BYTE_W-1:0])
                                   : sh_reg[i][lcfs_pkg::BYTE_W-1:0];
        end
    end

endmodule

### rtl/core/linear_color_fade_stepper_top.sv
// Top level of the linear color fade stepper: sequencer, blend multiply, I/O.
// Depends on lcfs_pkg, lcfs_track_store and lcfs_divider.
//
// The block keeps a table of fade tracks, each holding an accumulator in 1/32
// step units, a step count N, start and end bytes for three channels and the
// three blended bytes. A transfer on the s_ channel carries one command: start
// loads a track, step blends each channel as (start*(N-q) + end*q)/N with
// q = accumulator/32 (truncated toward zero, low byte kept) and then adds
// step_increment to the accumulator, read returns the stored bytes. Every
// command gives exactly one result transfer on the m_ channel. A step goes from
// the input transfer through the table lookup, the shared blend multiplier (one
// channel at a time), a divider load, the three-lane restoring divider that
// produces one quotient bit per cycle, then write-back and the output register.
// Start, read, a step on a track with N of zero and a track index outside the
// table skip the multiplier and divider: after the lookup their result goes
// straight to the output register. One command is in flight at a time; s_ready
// is high only while the sequencer is idle, and a finished result can sit in the
// output register while the next command is taken. The track table is cleared
// by reset, so no clearing pass is needed. cfg_wr_en / cfg_wr_data write
// step_increment (reset value 1) and are meant to be used only while no command
// is in flight.
module linear_color_fade_stepper_top #(
    parameter int NUM_TRACKS = lcfs_pkg::NUM_TRACKS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              cfg_wr_en,
    input  logic [lcfs_pkg::INC_W-1:0]        cfg_wr_data,

    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [lcfs_pkg::OPCODE_W-1:0]     s_opcode,
    input  logic [lcfs_pkg::TRACK_W-1:0]      s_track,
    input  logic [lcfs_pkg::BYTE_W-1:0]       s_start_c0,
    input  logic [lcfs_pkg::BYTE_W-1:0]       s_start_c1,
    input  logic [lcfs_pkg::BYTE_W-1:0]       s_start_c2,
    input  logic [lcfs_pkg::BYTE_W-1:0]       s_end_c0,
    input  logic [lcfs_pkg::BYTE_W-1:0]       s_end_c1,
    input  logic [lcfs_pkg::BYTE_W-1:0]       s_end_c2,
    input  logic [lcfs_pkg::STEPS_W-1:0]      s_total_steps,

    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [lcfs_pkg::BYTE_W-1:0]       m_out_c0,
    output logic [lcfs_pkg::BYTE_W-1:0]       m_out_c1,
    output logic [lcfs_pkg::BYTE_W-1:0]       m_out_c2,
    output logic                              m_done_res,
    output logic                              m_error
);

    // Only the tracks the 4-bit field can reach get storage.
    localparam int TRK_DEPTH = (NUM_TRACKS < lcfs_pkg::TRACK_SPAN) ? NUM_TRACKS
                                                                    : lcfs_pkg::TRACK_SPAN;
    localparam int IDX_W     = (TRK_DEPTH > 1) ? $clog2(TRK_DEPTH) : 1;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_EXEC = 5'b00010,
        ST_MUL  = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

    state_t                                   state_reg, state_next;

    // latched command
    logic [lcfs_pkg::OPCODE_W-1:0]            op_reg, op_next;
    logic [lcfs_pkg::TRACK_W-1:0]             trk_reg, trk_next;
    lcfs_pkg::bytes_t                         in_start_reg, in_start_next;
    lcfs_pkg::bytes_t                         in_end_reg, in_end_next;
    logic [lcfs_pkg::STEPS_W-1:0]             in_steps_reg, in_steps_next;

    // step working set
    lcfs_pkg::track_rec_t                     rec_reg, rec_next;
    logic signed [lcfs_pkg::Q_W-1:0]          q_reg, q_next;
    logic [lcfs_pkg::CH_W-1:0]                ch_reg, ch_next;
    logic [lcfs_pkg::CH_NUM-1:0][lcfs_pkg::NUM_W-1:0] num_reg, num_next;
    logic                                     div_start_reg, div_start_next;

    // pending result and output register
    lcfs_pkg::bytes_t                         res_bytes_reg, res_bytes_next;
    logic                                     res_done_reg, res_done_next;
    logic                                     res_err_reg, res_err_next;
    logic                                     m_valid_reg, m_valid_next;
    lcfs_pkg::bytes_t                         m_bytes_reg, m_bytes_next;
    logic                                     m_done_reg, m_done_next;
    logic                                     m_err_reg, m_err_next;

    logic signed [lcfs_pkg::INC_W-1:0]        step_inc_reg;

    // table ports
    lcfs_pkg::track_rec_t                     rd_rec;
    lcfs_pkg::track_rec_t                     wr_rec;
    logic                                     wr_en;
    logic [IDX_W-1:0]                         trk_idx;
    logic                                     in_range;

    // divider ports
    logic                                     div_done;
    lcfs_pkg::bytes_t                         div_quo;

    // blend datapath
    logic signed [lcfs_pkg::DIFF_W-1:0]       ch_diff;
    logic signed [lcfs_pkg::NUM_W-1:0]        ch_prod;
    logic [lcfs_pkg::SN_W-1:0]                ch_sn;
    logic [lcfs_pkg::ACC_W-1:0]               acc_new;
    logic [lcfs_pkg::ACC_W-1:0]               acc_lim;
    logic                                     q_round;

    assign trk_idx  = trk_reg[IDX_W-1:0];
    assign in_range = (32'(trk_reg) < NUM_TRACKS);
    assign s_ready  = (state_reg == ST_IDLE);

    lcfs_track_store #(
        .DEPTH (TRK_DEPTH)
    ) u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_idx  (trk_idx),
        .rd_rec  (rd_rec),
        .wr_en   (wr_en),
        .wr_idx  (trk_idx),
        .wr_rec  (wr_rec)
    );

    lcfs_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start_reg),
        .dividend (num_reg),
        .divisor  (rec_reg.steps),
        .done     (div_done),
        .quo_lo   (div_quo)
    );

    // q truncates toward zero: floor, plus one for a negative value with a fraction
    assign q_round = rd_rec.acc[lcfs_pkg::ACC_W-1] & (|rd_rec.acc[lcfs_pkg::FRAC_BITS-1:0]);

    // one channel per cycle: start*N + (end - start)*q
    always_comb begin
        ch_diff = $signed({1'b0, rec_reg.end_b[ch_reg]}) - $signed({1'b0, rec_reg.start_b[ch_reg]});
        ch_prod = ch_diff * q_reg;
        ch_sn   = rec_reg.start_b[ch_reg] * rec_reg.steps;
    end

    // accumulator advance and done test (signed compare against N*32)
    assign acc_new = rec_reg.acc + lcfs_pkg::ACC_W'(step_inc_reg);
    assign acc_lim = lcfs_pkg::ACC_W'(rec_reg.steps) << lcfs_pkg::FRAC_BITS;

    always_comb begin
        state_next     = state_reg;
        op_next        = op_reg;
        trk_next       = trk_reg;
        in_start_next  = in_start_reg;
        in_end_next    = in_end_reg;
        in_steps_next  = in_steps_reg;
        rec_next       = rec_reg;
        q_next         = q_reg;
        ch_next        = ch_reg;
        num_next       = num_reg;
        div_start_next = 1'b0;
        res_bytes_next = res_bytes_reg;
        res_done_next  = res_done_reg;
        res_err_next   = res_err_reg;
        m_valid_next   = m_valid_reg & ~m_ready;
        m_bytes_next   = m_bytes_reg;
        m_done_next    = m_done_reg;
        m_err_next     = m_err_reg;
        wr_en          = 1'b0;
        wr_rec         = rec_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    op_next       = s_opcode;
                    trk_next      = s_track;
                    in_start_next = {s_start_c2, s_start_c1, s_start_c0};
                    in_end_next   = {s_end_c2, s_end_c1, s_end_c0};
                    in_steps_next = s_total_steps;
                    state_next    = ST_EXEC;
                end
            end

            ST_EXEC: begin
                res_done_next = 1'b0;
                res_err_next  = 1'b0;
                state_next    = ST_OUT;
                if (!in_range) begin
                    res_bytes_next = '0;
                end else begin
                    unique case (op_reg)
                        lcfs_pkg::OP_START: begin
                            wr_en          = 1'b1;
                            wr_rec.acc     = lcfs_pkg::ACC_START;
                            wr_rec.steps   = in_steps_reg;
                            wr_rec.start_b = in_start_reg;
                            wr_rec.end_b   = in_end_reg;
                            wr_rec.blend   = in_start_reg;
                            res_bytes_next = in_start_reg;
                        end
                        lcfs_pkg::OP_STEP: begin
                            res_bytes_next = rd_rec.blend;
                            if (rd_rec.steps == '0) begin
                                res_err_next = 1'b1;
                            end else begin
                                rec_next   = rd_rec;
                                q_next     = rd_rec.acc[lcfs_pkg::ACC_W-1:lcfs_pkg::FRAC_BITS]
                                             + lcfs_pkg::Q_W'(q_round);
                                ch_next    = '0;
                                state_next = ST_MUL;
                            end
                        end
                        default: begin
                            res_bytes_next = rd_rec.blend;
                        end
                    endcase
                end
            end

            ST_MUL: begin
                num_next[ch_reg] = ch_prod + lcfs_pkg::NUM_W'(ch_sn);
                if (ch_reg == lcfs_pkg::CH_W'(lcfs_pkg::CH_NUM - 1)) begin
                    div_start_next = 1'b1;
                    state_next     = ST_DIV;
                end else begin
                    ch_next = ch_reg + 1'b1;
                end
            end

            ST_DIV: begin
                if (div_done) begin
                    wr_en          = 1'b1;
                    wr_rec.blend   = div_quo;
                    wr_rec.acc     = acc_new;
                    res_bytes_next = div_quo;
                    res_done_next  = ($signed(acc_new) > $signed(acc_lim));
                    state_next     = ST_OUT;
                end
            end

            ST_OUT: begin
                // load when the output register is empty or being drained
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_bytes_next = res_bytes_reg;
                    m_done_next  = res_done_reg;
                    m_err_next   = res_err_reg;
                    state_next   = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            div_start_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
            step_inc_reg  <= lcfs_pkg::INC_RESET;
        end else begin
            state_reg     <= state_next;
            div_start_reg <= div_start_next;
            m_valid_reg   <= m_valid_next;
            if (cfg_wr_en) begin
                step_inc_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        op_reg        <= op_next;
        trk_reg       <= trk_next;
        in_start_reg  <= in_start_next;
        in_end_reg    <= in_end_next;
        in_steps_reg  <= in_steps_next;
        rec_reg       <= rec_next;
        q_reg         <= q_next;
        ch_reg        <= ch_next;
        num_reg       <= num_next;
        res_bytes_reg <= res_bytes_next;
        res_done_reg  <= res_done_next;
        res_err_reg   <= res_err_next;
        m_bytes_reg   <= m_bytes_next;
        m_done_reg    <= m_done_next;
        m_err_reg     <= m_err_next;
    end

    assign m_valid    = m_valid_reg;
    assign m_out_c0   = m_bytes_reg[0];
    assign m_out_c1   = m_bytes_reg[1];
    assign m_out_c2   = m_bytes_reg[2];
    assign m_done_res = m_done_reg;
    assign m_error    = m_err_reg;

endmodule
